// File: rtl/smr90_pkg.sv
`default_nettype none

package smr90_pkg;

  // Fixed field widths
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned SIZE_W = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam int unsigned MAX_SIDE_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

endpackage

`default_nettype wire

// File: rtl/smr90_front.sv
`default_nettype none

// Accepts items, tracks the write and read positions and turns each item into
// a memory command with its final address.
module smr90_front #(
  parameter int unsigned MAX_SIDE   = smr90_pkg::MAX_SIDE_DEF,
  parameter int unsigned DATA_WIDTH = smr90_pkg::DATA_WIDTH_DEF,
  parameter int unsigned ADDR_W     = $clog2(MAX_SIDE * MAX_SIDE),
  parameter int unsigned ENTRY_W    = ADDR_W + DATA_WIDTH + 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [smr90_pkg::SIZE_W-1:0]   cfg_matrix_size_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           op_i,
  input  wire logic signed [smr90_pkg::ELEM_W-1:0] element_value_i,
  output logic                                push_valid_o,
  input  wire logic                           push_ready_i,
  output logic [ENTRY_W-1:0]                  push_entry_o
);

  localparam int unsigned POS_W  = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned CMP_W  = (SIDE_W > smr90_pkg::SIZE_W) ? SIDE_W : smr90_pkg::SIZE_W;
  localparam int unsigned EXT_W  = (DATA_WIDTH > smr90_pkg::ELEM_W) ? DATA_WIDTH
                                                                    : smr90_pkg::ELEM_W;

  typedef struct packed {
    smr90_pkg::op_e          op;
    logic [ADDR_W-1:0]       addr;
    logic [DATA_WIDTH-1:0]   data;
    logic                    last;
  } entry_t;

  logic [smr90_pkg::SIZE_W-1:0] size_q;
  logic [POS_W-1:0] wr_row_q, wr_row_d, wr_col_q, wr_col_d;
  logic [POS_W-1:0] rd_row_q, rd_row_d, rd_col_q, rd_col_d;

  logic [CMP_W-1:0]  size_cmp;
  logic [SIDE_W-1:0] side;
  logic [POS_W-1:0]  side_m1;
  logic [POS_W-1:0]  row, col;
  logic [POS_W-1:0]  src_row, src_col;
  logic [POS_W-1:0]  nxt_row, nxt_col;
  logic [EXT_W-1:0]  elem_ext;
  logic              accept;
  entry_t            entry;

  assign cfg_ready_o = 1'b1;

  // Clamp the side length to 1..MAX_SIDE
  always_comb begin
    size_cmp = CMP_W'(size_q);
    if (size_cmp == '0) begin
      side = SIDE_W'(1);
    end else if (size_cmp > CMP_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(size_cmp);
    end
  end

  assign side_m1 = POS_W'(side - SIDE_W'(1));

  // A position left outside a smaller matrix restarts at the origin
  always_comb begin
    if (op_i == smr90_pkg::OP_READ) begin
      row = rd_row_q;
      col = rd_col_q;
    end else begin
      row = wr_row_q;
      col = wr_col_q;
    end
    if (SIDE_W'(row) >= side || SIDE_W'(col) >= side) begin
      row = '0;
      col = '0;
    end
  end

  always_comb begin
    if (col == side_m1) begin
      nxt_col = '0;
      nxt_row = (row == side_m1) ? '0 : POS_W'(row + POS_W'(1));
    end else begin
      nxt_col = POS_W'(col + POS_W'(1));
      nxt_row = row;
    end
  end

  assign src_row  = POS_W'(side_m1 - col);
  assign src_col  = row;
  assign elem_ext = EXT_W'($unsigned(element_value_i));

  always_comb begin
    entry.op   = smr90_pkg::op_e'(op_i);
    entry.data = elem_ext[DATA_WIDTH-1:0];
    entry.last = 1'b0;
    if (op_i == smr90_pkg::OP_READ) begin
      entry.addr = ADDR_W'(ADDR_W'(src_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(src_col));
      entry.last = (row == side_m1) && (col == side_m1);
    end else begin
      entry.addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_SIDE) + ADDR_W'(col));
    end
  end

  assign accept       = in_valid_i && push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign push_entry_o = entry;

  always_comb begin
    wr_row_d = wr_row_q;
    wr_col_d = wr_col_q;
    rd_row_d = rd_row_q;
    rd_col_d = rd_col_q;
    if (accept) begin
      if (op_i == smr90_pkg::OP_READ) begin
        rd_row_d = nxt_row;
        rd_col_d = nxt_col;
      end else begin
        wr_row_d = nxt_row;
        wr_col_d = nxt_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= smr90_pkg::SIZE_RESET;
      wr_row_q <= '0;
      wr_col_q <= '0;
      rd_row_q <= '0;
      rd_col_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        size_q <= cfg_matrix_size_i;
      end
      wr_row_q <= wr_row_d;
      wr_col_q <= wr_col_d;
      rd_row_q <= rd_row_d;
      rd_col_q <= rd_col_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/smr90_queue.sv
`default_nettype none

// Two-entry FIFO between the front and the back
module smr90_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int unsigned CNT_W = $clog2(smr90_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [smr90_pkg::QUEUE_DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(smr90_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
      end else if (pop && !push) begin
        cnt_q <= CNT_W'(cnt_q - CNT_W'(1));
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/smr90_back.sv
`default_nettype none

// Carries out memory commands in order; the read data register is the output
// register.
module smr90_back #(
  parameter int unsigned MAX_SIDE   = smr90_pkg::MAX_SIDE_DEF,
  parameter int unsigned DATA_WIDTH = smr90_pkg::DATA_WIDTH_DEF,
  parameter int unsigned ADDR_W     = $clog2(MAX_SIDE * MAX_SIDE),
  parameter int unsigned ENTRY_W    = ADDR_W + DATA_WIDTH + 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               pop_valid_i,
  output logic                    pop_ready_o,
  input  wire logic [ENTRY_W-1:0] pop_entry_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [smr90_pkg::ELEM_W-1:0] rotated_value_o,
  output logic                    last_of_matrix_o
);

  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned EXT_W = (DATA_WIDTH > smr90_pkg::ELEM_W) ? DATA_WIDTH
                                                                   : smr90_pkg::ELEM_W;

  typedef struct packed {
    smr90_pkg::op_e          op;
    logic [ADDR_W-1:0]       addr;
    logic [DATA_WIDTH-1:0]   data;
    logic                    last;
  } entry_t;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  last_q;
  logic                  out_valid_q;
  logic [EXT_W-1:0]      rd_ext;
  logic                  slot_free;
  logic                  do_wr, do_rd;
  entry_t                entry;

  assign entry       = entry_t'(pop_entry_i);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_ready_o = (entry.op == smr90_pkg::OP_WRITE) || slot_free;
  assign do_wr       = pop_valid_i && (entry.op == smr90_pkg::OP_WRITE);
  assign do_rd       = pop_valid_i && (entry.op == smr90_pkg::OP_READ) && slot_free;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[entry.addr] <= entry.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_rd) begin
      rd_data_q <= mem_q[entry.addr];
      last_q    <= entry.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_rd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rd_ext           = EXT_W'($signed(rd_data_q));
  assign rotated_value_o  = rd_ext[smr90_pkg::ELEM_W-1:0];
  assign last_of_matrix_o = last_q;
  assign out_valid_o      = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/square_matrix_rotate_90.sv
// Rotates an n by n matrix 90 degrees clockwise. Write items (op 0) load the
// matrix row by row; read items (op 1) return the rotated matrix row by row,
// one result each, with last_of_matrix on the final element. The write and
// read positions wrap after n*n items on their own. The side n comes from the
// config register (0 acts as 1, values above MAX_SIDE act as MAX_SIDE); the
// user must change it only while the block is idle, which the block does not
// enforce. The front computes the address, a two-entry queue decouples it
// from the back, which does one access per cycle (a read waits while the
// output holds an untaken result) on a single-port MAX_SIDE*MAX_SIDE word
// memory. A read result is registered; unwritten entries read undefined data.
`default_nettype none

module square_matrix_rotate_90 #(
  parameter int unsigned MAX_SIDE   = smr90_pkg::MAX_SIDE_DEF,
  parameter int unsigned DATA_WIDTH = smr90_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [smr90_pkg::SIZE_W-1:0]        cfg_matrix_size_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                op_i,
  input  wire logic signed [smr90_pkg::ELEM_W-1:0] element_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [smr90_pkg::ELEM_W-1:0]      rotated_value_o,
  output logic                                     last_of_matrix_o
);

  localparam int unsigned ADDR_W  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int unsigned ENTRY_W = ADDR_W + DATA_WIDTH + 2;

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_entry;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_entry;

  smr90_front #(
    .MAX_SIDE   (MAX_SIDE),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_matrix_size_i (cfg_matrix_size_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .element_value_i   (element_value_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_entry_o      (push_entry)
  );

  smr90_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_entry)
  );

  smr90_back #(
    .MAX_SIDE   (MAX_SIDE),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_entry_i      (pop_entry),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .rotated_value_o  (rotated_value_o),
    .last_of_matrix_o (last_of_matrix_o)
  );

endmodule

`default_nettype wire
